// File: design/gso_pkg.sv
// Shared constants, widths and fixed-point helpers for the Gram-Schmidt core.
`timescale 1ns / 1ps
package gso_pkg;

  // Width of every matrix entry on the ports.
  localparam int DATA_WIDTH = 32;

  // Internal Q.28 residual width: residual components stay below about 2^33.
  localparam int VW = 35;
  // Unit components in Q.30, magnitude at most 2^30.
  localparam int UW = 32;
  // The largest scaled magnitude lies in [2^30, 2^31].
  localparam int MW = 32;
  // Sum of squares width.
  localparam int SW = 64;
  // Wide scratch width for rounding shifts.
  localparam int WW = 72;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;

  // Normalizer: magnitude, max, scale, square, sum, root, divide, sign.
  localparam int UNIT_LAT = 5 + SQRT_STEPS + DIV_STEPS + 1;
  // Projection removal: products, dot product, scale, subtract.
  localparam int PROJ_LAT = 4;
  localparam int TOTAL_LAT = 3 * UNIT_LAT + 2 * PROJ_LAT;

  // Round to nearest, ties away from zero, while shifting right by k (k >= 1).
  function automatic logic signed [WW-1:0] rshr(input logic signed [WW-1:0] x,
                                                input int k);
    logic           neg;
    logic [WW-1:0]  mag;
    neg = x[WW-1];
    mag = neg ? WW'(-x) : WW'(x);
    mag = (mag + (WW'(1) << (k - 1))) >> k;
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  // Port entry with DATA_WIDTH-4 fraction bits to internal Q.28.
  function automatic logic signed [VW-1:0] to_q28(input logic signed [DATA_WIDTH-1:0] x);
    logic signed [WW-1:0] w;
    w = WW'(x);
    if (DATA_WIDTH > 32) begin
      w = rshr(w, DATA_WIDTH - 32);
    end else begin
      w = w <<< (32 - DATA_WIDTH);
    end
    return VW'(w);
  endfunction

  // Internal Q.30 unit component to a port entry with DATA_WIDTH-2 fraction bits.
  function automatic logic signed [DATA_WIDTH-1:0] from_q30(input logic signed [UW-1:0] u);
    logic signed [WW-1:0] w;
    w = WW'(u);
    if (DATA_WIDTH >= 32) begin
      w = w <<< (DATA_WIDTH - 32);
    end else begin
      w = rshr(w, 32 - DATA_WIDTH);
    end
    return DATA_WIDTH'(w);
  endfunction

endpackage

// File: design/gram_schmidt_3x3_orthonormalize_core.sv
// Top level of the 3x3 Gram-Schmidt orthonormalization pipeline.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   input   | in_valid / in_ready  | in_rR_cC, nine signed Q3.28 entries
//   result  | out_valid / out_ready| out_rR_cC signed Q1.30, out_degenerate
//
// One matrix enters per cycle while in_ready is high; each result passes three normalizers
// in series, each a 32-stage root and 32-stage divider lanes. Reset (rst_n low,
// synchronous) empties the pipeline and output slots. A stalled result is held in the
// output register while a skid register takes one more; in_ready drops only while the
// skid register is full.
`timescale 1ns / 1ps
module gram_schmidt_3x3_orthonormalize_core (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [gso_pkg::DATA_WIDTH-1:0]    in_r0_c0,
  input  logic signed [gso_pkg::DATA_WIDTH-1:0]    in_r0_c1,
  input  logic signed [gso_pkg::DATA_WIDTH-1:0]    in_r0_c2,
  input  logic signed [gso_pkg::DATA_WIDTH-1:0]    in_r1_c0,
  input  logic signed [gso_pkg::DATA_WIDTH-1:0]    in_r1_c1,
  input  logic signed [gso_pkg::DATA_WIDTH-1:0]    in_r1_c2,
  input  logic signed [gso_pkg::DATA_WIDTH-1:0]    in_r2_c0,
  input  logic signed [gso_pkg::DATA_WIDTH-1:0]    in_r2_c1,
  input  logic signed [gso_pkg::DATA_WIDTH-1:0]    in_r2_c2,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [gso_pkg::DATA_WIDTH-1:0]    out_r0_c0,
  output logic signed [gso_pkg::DATA_WIDTH-1:0]    out_r0_c1,
  output logic signed [gso_pkg::DATA_WIDTH-1:0]    out_r0_c2,
  output logic signed [gso_pkg::DATA_WIDTH-1:0]    out_r1_c0,
  output logic signed [gso_pkg::DATA_WIDTH-1:0]    out_r1_c1,
  output logic signed [gso_pkg::DATA_WIDTH-1:0]    out_r1_c2,
  output logic signed [gso_pkg::DATA_WIDTH-1:0]    out_r2_c0,
  output logic signed [gso_pkg::DATA_WIDTH-1:0]    out_r2_c1,
  output logic signed [gso_pkg::DATA_WIDTH-1:0]    out_r2_c2,
  output logic                                     out_degenerate
);

  localparam int UL = gso_pkg::UNIT_LAT;
  localparam int PL = gso_pkg::PROJ_LAT;
  localparam int DW = gso_pkg::DATA_WIDTH;

  typedef struct packed {
    logic                       degenerate;
    logic [8:0][DW-1:0]         ent;
  } res_t;

  logic                           en;
  logic                           vld_r [gso_pkg::TOTAL_LAT];
  logic signed [gso_pkg::VW-1:0]  v0 [3];
  logic signed [gso_pkg::VW-1:0]  v1 [3];
  logic signed [gso_pkg::VW-1:0]  v2 [3];

  // First normalizer window.
  logic signed [gso_pkg::VW-1:0]  s1_v1_r [UL][3];
  logic signed [gso_pkg::VW-1:0]  s1_v2_r [UL][3];
  logic signed [gso_pkg::UW-1:0]  u0 [3];
  logic                           ok0;
  // First projection window.
  logic signed [gso_pkg::VW-1:0]  v1p [3];
  logic signed [gso_pkg::VW-1:0]  v2p [3];
  logic signed [gso_pkg::UW-1:0]  s2_u0_r [PL][3];
  logic                           s2_ok0_r [PL];
  // Second normalizer window.
  logic signed [gso_pkg::UW-1:0]  u1 [3];
  logic                           ok1;
  logic signed [gso_pkg::UW-1:0]  s3_u0_r [UL][3];
  logic signed [gso_pkg::VW-1:0]  s3_v2_r [UL][3];
  logic                           s3_ok0_r [UL];
  // Second projection window.
  logic signed [gso_pkg::VW-1:0]  v2pp [3];
  logic signed [gso_pkg::UW-1:0]  s4_u0_r [PL][3];
  logic signed [gso_pkg::UW-1:0]  s4_u1_r [PL][3];
  logic                           s4_ok_r [PL];
  // Third normalizer window.
  logic signed [gso_pkg::UW-1:0]  u2 [3];
  logic                           ok2;
  logic signed [gso_pkg::UW-1:0]  s5_u0_r [UL][3];
  logic signed [gso_pkg::UW-1:0]  s5_u1_r [UL][3];
  logic                           s5_ok_r [UL];

  res_t  res;
  res_t  out_r;
  res_t  skid_r;
  logic  out_valid_r;
  logic  skid_valid_r;

  // The pipeline moves whenever the skid register is free.
  assign en       = !skid_valid_r;
  assign in_ready = en;

  // Input entries to internal Q.28.
  always_comb begin
    v0[0] = gso_pkg::to_q28(in_r0_c0);
    v0[1] = gso_pkg::to_q28(in_r0_c1);
    v0[2] = gso_pkg::to_q28(in_r0_c2);
    v1[0] = gso_pkg::to_q28(in_r1_c0);
    v1[1] = gso_pkg::to_q28(in_r1_c1);
    v1[2] = gso_pkg::to_q28(in_r1_c2);
    v2[0] = gso_pkg::to_q28(in_r2_c0);
    v2[1] = gso_pkg::to_q28(in_r2_c1);
    v2[2] = gso_pkg::to_q28(in_r2_c2);
  end

  // Beat valid bits follow the data through every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gso_pkg::TOTAL_LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < gso_pkg::TOTAL_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Normalize the first row.
  gso_unit3 u_unit0 (.clk(clk), .en(en), .v_i(v0), .u_o(u0), .ok_o(ok0));

  always_ff @(posedge clk) begin
    if (en) begin
      s1_v1_r[0] <= v1;
      s1_v2_r[0] <= v2;
      for (int i = 1; i < UL; i++) begin
        s1_v1_r[i] <= s1_v1_r[i-1];
        s1_v2_r[i] <= s1_v2_r[i-1];
      end
    end
  end

  // Remove the first unit row from the second and third rows.
  gso_proj u_proj01 (.clk(clk), .en(en), .u_i(u0), .v_i(s1_v1_r[UL-1]), .v_o(v1p));
  gso_proj u_proj02 (.clk(clk), .en(en), .u_i(u0), .v_i(s1_v2_r[UL-1]), .v_o(v2p));

  always_ff @(posedge clk) begin
    if (en) begin
      s2_u0_r[0]  <= u0;
      s2_ok0_r[0] <= ok0;
      for (int i = 1; i < PL; i++) begin
        s2_u0_r[i]  <= s2_u0_r[i-1];
        s2_ok0_r[i] <= s2_ok0_r[i-1];
      end
    end
  end

  // Normalize the second residual.
  gso_unit3 u_unit1 (.clk(clk), .en(en), .v_i(v1p), .u_o(u1), .ok_o(ok1));

  always_ff @(posedge clk) begin
    if (en) begin
      s3_u0_r[0]  <= s2_u0_r[PL-1];
      s3_ok0_r[0] <= s2_ok0_r[PL-1];
      s3_v2_r[0]  <= v2p;
      for (int i = 1; i < UL; i++) begin
        s3_u0_r[i]  <= s3_u0_r[i-1];
        s3_ok0_r[i] <= s3_ok0_r[i-1];
        s3_v2_r[i]  <= s3_v2_r[i-1];
      end
    end
  end

  // Remove the second unit row from the third residual.
  gso_proj u_proj12 (.clk(clk), .en(en), .u_i(u1), .v_i(s3_v2_r[UL-1]), .v_o(v2pp));

  always_ff @(posedge clk) begin
    if (en) begin
      s4_u0_r[0] <= s3_u0_r[UL-1];
      s4_u1_r[0] <= u1;
      s4_ok_r[0] <= s3_ok0_r[UL-1] && ok1;
      for (int i = 1; i < PL; i++) begin
        s4_u0_r[i] <= s4_u0_r[i-1];
        s4_u1_r[i] <= s4_u1_r[i-1];
        s4_ok_r[i] <= s4_ok_r[i-1];
      end
    end
  end

  // Normalize the third residual.
  gso_unit3 u_unit2 (.clk(clk), .en(en), .v_i(v2pp), .u_o(u2), .ok_o(ok2));

  always_ff @(posedge clk) begin
    if (en) begin
      s5_u0_r[0] <= s4_u0_r[PL-1];
      s5_u1_r[0] <= s4_u1_r[PL-1];
      s5_ok_r[0] <= s4_ok_r[PL-1];
      for (int i = 1; i < UL; i++) begin
        s5_u0_r[i] <= s5_u0_r[i-1];
        s5_u1_r[i] <= s5_u1_r[i-1];
        s5_ok_r[i] <= s5_ok_r[i-1];
      end
    end
  end

  // Assemble the result; a zero row or residual clears all entries.
  always_comb begin
    res.degenerate = !(s5_ok_r[UL-1] && ok2);
    for (int c = 0; c < 3; c++) begin
      res.ent[c]     = res.degenerate ? '0 : gso_pkg::from_q30(s5_u0_r[UL-1][c]);
      res.ent[3 + c] = res.degenerate ? '0 : gso_pkg::from_q30(s5_u1_r[UL-1][c]);
      res.ent[6 + c] = res.degenerate ? '0 : gso_pkg::from_q30(u2[c]);
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (vld_r[gso_pkg::TOTAL_LAT-1]) begin
      if (!out_valid_r || out_ready) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_degenerate = out_r.degenerate;
  assign out_r0_c0      = out_r.ent[0];
  assign out_r0_c1      = out_r.ent[1];
  assign out_r0_c2      = out_r.ent[2];
  assign out_r1_c0      = out_r.ent[3];
  assign out_r1_c1      = out_r.ent[4];
  assign out_r1_c2      = out_r.ent[5];
  assign out_r2_c0      = out_r.ent[6];
  assign out_r2_c1      = out_r.ent[7];
  assign out_r2_c2      = out_r.ent[8];

endmodule

// File: design/gso_div_lane.sv
// One divider lane: pipelined restoring division of a scaled magnitude by the norm.
`timescale 1ns / 1ps
module gso_div_lane (
  input  logic                      clk,
  input  logic                      en,
  input  logic [gso_pkg::MW-1:0]    m_i,
  input  logic [gso_pkg::MW-1:0]    n_i,
  output logic [gso_pkg::MW-1:0]    quot_o
);

  logic [gso_pkg::MW-1:0] rem_r  [gso_pkg::DIV_STEPS];
  logic [gso_pkg::MW-1:0] den_r  [gso_pkg::DIV_STEPS];
  logic [gso_pkg::MW-1:0] quot_r [gso_pkg::DIV_STEPS];

  // Dividend is m * 2^31; the first step sees m itself, later steps shift in zeros.
  genvar j;
  for (j = 0; j < gso_pkg::DIV_STEPS; j++) begin : g_step
    logic [gso_pkg::MW:0]   rem2;
    logic [gso_pkg::MW-1:0] den_in;
    logic [gso_pkg::MW-1:0] quot_in;
    logic                   ge;
    logic [gso_pkg::MW-1:0] rem_nxt;
    logic [gso_pkg::MW-1:0] quot_nxt;

    if (j == 0) begin : g_first
      assign rem2    = {1'b0, m_i};
      assign den_in  = n_i;
      assign quot_in = '0;
    end else begin : g_next
      assign rem2    = {rem_r[j-1], 1'b0};
      assign den_in  = den_r[j-1];
      assign quot_in = quot_r[j-1];
    end

    // One quotient bit per stage.
    always_comb begin
      ge       = rem2 >= {1'b0, den_in};
      rem_nxt  = ge ? gso_pkg::MW'(rem2 - {1'b0, den_in}) : gso_pkg::MW'(rem2);
      quot_nxt = {quot_in[gso_pkg::MW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        den_r[j]  <= den_in;
        quot_r[j] <= quot_nxt;
      end
    end
  end

  assign quot_o = quot_r[gso_pkg::DIV_STEPS-1];

endmodule

// File: design/gso_unit3.sv
// Triple normalizer: scale, sum of squares, pipelined root and three divider lanes.
`timescale 1ns / 1ps
module gso_unit3 (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [gso_pkg::VW-1:0]     v_i [3],
  output logic signed [gso_pkg::UW-1:0]     u_o [3],
  output logic                              ok_o
);

  typedef struct packed {
    logic [2:0]                   sgn;
    logic                         nz;
    logic [2:0][gso_pkg::MW-1:0]  ms;
  } side_t;

  typedef struct packed {
    logic [2:0] sgn;
    logic       nz;
  } dside_t;

  localparam logic [gso_pkg::VW-1:0] ONE_Q30 = gso_pkg::VW'(64'd1 << 30);
  localparam logic [gso_pkg::VW-1:0] TOP_Q31 = gso_pkg::VW'(64'd1 << 31);

  logic [gso_pkg::VW-1:0]  a_mag_r [3];
  logic [2:0]              a_sgn_r;
  logic [gso_pkg::VW-1:0]  b_mag_r [3];
  logic [2:0]              b_sgn_r;
  logic [gso_pkg::VW-1:0]  b_mx_r;
  logic [gso_pkg::VW-1:0]  mx_nxt;
  logic [5:0]              dn_sh;
  logic [4:0]              up_sh;
  side_t                   c_side_nxt;
  side_t                   c_side_r;
  side_t                   d_side_r;
  side_t                   e_side_r;
  logic [gso_pkg::SW-1:0]  d_sq_r [3];
  logic [gso_pkg::SW-1:0]  e_sum_r;
  logic [gso_pkg::SW-1:0]  sq_s_r [gso_pkg::SQRT_STEPS];
  logic [gso_pkg::SW-1:0]  sq_r_r [gso_pkg::SQRT_STEPS];
  side_t                   sq_side_r [gso_pkg::SQRT_STEPS];
  dside_t                  dv_side_r [gso_pkg::DIV_STEPS];
  logic [gso_pkg::MW-1:0]  norm;
  logic [gso_pkg::MW-1:0]  quot [3];
  logic signed [gso_pkg::UW-1:0] u_r [3];
  logic                    ok_r;

  // Stage A: component magnitudes and signs.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_sgn_r[i] <= v_i[i][gso_pkg::VW-1];
        a_mag_r[i] <= v_i[i][gso_pkg::VW-1] ? gso_pkg::VW'(-v_i[i]) : gso_pkg::VW'(v_i[i]);
      end
    end
  end

  // Stage B: largest magnitude.
  always_comb begin
    mx_nxt = a_mag_r[0];
    if (a_mag_r[1] > mx_nxt) mx_nxt = a_mag_r[1];
    if (a_mag_r[2] > mx_nxt) mx_nxt = a_mag_r[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_mag_r <= a_mag_r;
      b_sgn_r <= a_sgn_r;
      b_mx_r  <= mx_nxt;
    end
  end

  // Stage C: common power-of-two scale that puts the largest into [2^30, 2^31].
  always_comb begin
    dn_sh = '0;
    up_sh = '0;
    for (int k = gso_pkg::VW - 1; k >= 0; k--) begin
      if ((b_mx_r >> k) <= TOP_Q31) dn_sh = 6'(k);
    end
    for (int k = 30; k >= 0; k--) begin
      if (({31'b0, b_mx_r} << k) >= {31'b0, ONE_Q30}) up_sh = 5'(k);
    end
    c_side_nxt.sgn = b_sgn_r;
    c_side_nxt.nz  = b_mx_r != '0;
    for (int i = 0; i < 3; i++) begin
      if (b_mx_r > TOP_Q31) begin
        c_side_nxt.ms[i] = gso_pkg::MW'(b_mag_r[i] >> dn_sh);
      end else begin
        c_side_nxt.ms[i] = gso_pkg::MW'(b_mag_r[i] << up_sh);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side_r <= c_side_nxt;
    end
  end

  // Stage D: squares, one multiplier per lane.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_sq_r[i] <= gso_pkg::SW'(c_side_r.ms[i]) * gso_pkg::SW'(c_side_r.ms[i]);
      end
      d_side_r <= c_side_r;
    end
  end

  // Stage E: merge the lane squares.
  always_ff @(posedge clk) begin
    if (en) begin
      e_sum_r  <= d_sq_r[0] + d_sq_r[1] + d_sq_r[2];
      e_side_r <= d_side_r;
    end
  end

  // Integer square root, one result bit per stage.
  genvar k;
  for (k = 0; k < gso_pkg::SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [gso_pkg::SW-1:0] STEP_BIT = gso_pkg::SW'(1) << (62 - 2 * k);
    logic [gso_pkg::SW-1:0] s_in;
    logic [gso_pkg::SW-1:0] r_in;
    logic [gso_pkg::SW-1:0] trial;
    logic [gso_pkg::SW-1:0] s_nxt;
    logic [gso_pkg::SW-1:0] r_nxt;
    side_t                  side_in;

    if (k == 0) begin : g_first
      assign s_in    = e_sum_r;
      assign r_in    = '0;
      assign side_in = e_side_r;
    end else begin : g_next
      assign s_in    = sq_s_r[k-1];
      assign r_in    = sq_r_r[k-1];
      assign side_in = sq_side_r[k-1];
    end

    always_comb begin
      trial = r_in + STEP_BIT;
      if (s_in >= trial) begin
        s_nxt = s_in - trial;
        r_nxt = (r_in >> 1) + STEP_BIT;
      end else begin
        s_nxt = s_in;
        r_nxt = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_s_r[k]    <= s_nxt;
        sq_r_r[k]    <= r_nxt;
        sq_side_r[k] <= side_in;
      end
    end
  end

  assign norm = gso_pkg::MW'(sq_r_r[gso_pkg::SQRT_STEPS-1]);

  // Divider lanes, one per component.
  genvar l;
  for (l = 0; l < 3; l++) begin : g_lane
    gso_div_lane u_div (
      .clk    (clk),
      .en     (en),
      .m_i    (sq_side_r[gso_pkg::SQRT_STEPS-1].ms[l]),
      .n_i    (norm),
      .quot_o (quot[l])
    );
  end

  // Signs and the nonzero flag ride alongside the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      dv_side_r[0].sgn <= sq_side_r[gso_pkg::SQRT_STEPS-1].sgn;
      dv_side_r[0].nz  <= sq_side_r[gso_pkg::SQRT_STEPS-1].nz;
      for (int j = 1; j < gso_pkg::DIV_STEPS; j++) begin
        dv_side_r[j] <= dv_side_r[j-1];
      end
    end
  end

  // Final stage: round the half-step quotient and restore the sign.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= dv_side_r[gso_pkg::DIV_STEPS-1].sgn[i]
                  ? -$signed(gso_pkg::UW'((33'(quot[i]) + 33'd1) >> 1))
                  :  $signed(gso_pkg::UW'((33'(quot[i]) + 33'd1) >> 1));
      end
      ok_r <= dv_side_r[gso_pkg::DIV_STEPS-1].nz;
    end
  end

  assign u_o  = u_r;
  assign ok_o = ok_r;

endmodule

// File: design/gso_proj.sv
// Projection removal: v minus (u . v) u with per-lane multipliers and a merged dot product.
`timescale 1ns / 1ps
module gso_proj (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [gso_pkg::UW-1:0]   u_i [3],
  input  logic signed [gso_pkg::VW-1:0]   v_i [3],
  output logic signed [gso_pkg::VW-1:0]   v_o [3]
);

  localparam int PW = gso_pkg::UW + gso_pkg::VW;

  logic signed [PW-1:0]           p1_prod_r [3];
  logic signed [gso_pkg::UW-1:0]  p1_u_r [3];
  logic signed [gso_pkg::VW-1:0]  p1_v_r [3];
  logic signed [gso_pkg::WW-1:0]  dot;
  logic signed [gso_pkg::VW-1:0]  p2_p_r;
  logic signed [gso_pkg::UW-1:0]  p2_u_r [3];
  logic signed [gso_pkg::VW-1:0]  p2_v_r [3];
  logic signed [PW-1:0]           p3_t_r [3];
  logic signed [gso_pkg::VW-1:0]  p3_v_r [3];
  logic signed [gso_pkg::VW-1:0]  p4_v_r [3];

  // Lane products u_i * v_i.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_prod_r[i] <= PW'(u_i[i]) * PW'(v_i[i]);
      end
      p1_u_r <= u_i;
      p1_v_r <= v_i;
    end
  end

  // Dot product back to Q.28.
  assign dot = gso_pkg::WW'(p1_prod_r[0]) + gso_pkg::WW'(p1_prod_r[1])
             + gso_pkg::WW'(p1_prod_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      p2_p_r <= gso_pkg::VW'(gso_pkg::rshr(dot, 30));
      p2_u_r <= p1_u_r;
      p2_v_r <= p1_v_r;
    end
  end

  // Scaled unit components.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p3_t_r[i] <= PW'(p2_p_r) * PW'(p2_u_r[i]);
      end
      p3_v_r <= p2_v_r;
    end
  end

  // Subtract the rounded projection.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p4_v_r[i] <= p3_v_r[i]
                     - gso_pkg::VW'(gso_pkg::rshr(gso_pkg::WW'(p3_t_r[i]), 30));
      end
    end
  end

  assign v_o = p4_v_r;

endmodule

// File: design/gso_checker.sv
// Port-level checks for the Gram-Schmidt core and their binding to the top level.
`timescale 1ns / 1ps
module gso_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_ready,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic signed [gso_pkg::DATA_WIDTH-1:0]  out_r0_c0,
  input  logic signed [gso_pkg::DATA_WIDTH-1:0]  out_r0_c1,
  input  logic signed [gso_pkg::DATA_WIDTH-1:0]  out_r0_c2,
  input  logic signed [gso_pkg::DATA_WIDTH-1:0]  out_r1_c0,
  input  logic signed [gso_pkg::DATA_WIDTH-1:0]  out_r1_c1,
  input  logic signed [gso_pkg::DATA_WIDTH-1:0]  out_r1_c2,
  input  logic signed [gso_pkg::DATA_WIDTH-1:0]  out_r2_c0,
  input  logic signed [gso_pkg::DATA_WIDTH-1:0]  out_r2_c1,
  input  logic signed [gso_pkg::DATA_WIDTH-1:0]  out_r2_c2,
  input  logic                                   out_degenerate
);

  // A stalled result beat holds its degenerate flag and its first and last entries.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_degenerate)
                                && $stable(out_r0_c0) && $stable(out_r2_c2))
    else $error("result beat changed while stalled");

  // Reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A degenerate matrix gives all-zero entries.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_r0_c0 == 0 && out_r0_c1 == 0 && out_r0_c2 == 0 &&
      out_r1_c0 == 0 && out_r1_c1 == 0 && out_r1_c2 == 0 &&
      out_r2_c0 == 0 && out_r2_c1 == 0 && out_r2_c2 == 0)
    else $error("degenerate result with nonzero entries");

  // Input stall only ever comes with a result waiting downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

endmodule

bind gram_schmidt_3x3_orthonormalize_core gso_checker u_gso_checker (.*);
